>>> hw/rtl/scan_proximity_alert_macros.svh
`ifndef SCAN_PROXIMITY_ALERT_MACROS_SVH
`define SCAN_PROXIMITY_ALERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/spa_pkg.sv
package spa_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int RED_TURNS_DEF   = 3;
  localparam int GREEN_TURNS_DEF = 20;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  localparam logic [15:0] NEAR_LIMIT_RST    = 16'd2000;
  localparam logic [15:0] WARN_LIMIT_RST    = 16'd4000;
  localparam logic [14:0] WINDOW_START_RST  = 15'd0;
  localparam logic [14:0] WINDOW_END_RST    = 15'd23040;
  localparam logic [5:0]  QUALITY_FLOOR_RST = 6'd0;
  localparam logic [15:0] OBJECT_LIMIT_RST  = 16'd4000;
  localparam logic [15:0] INITIAL_MIN_RST   = 16'd65535;

  typedef enum logic [2:0] {
    CFG_NEAR_LIMIT    = 3'd0,
    CFG_WARN_LIMIT    = 3'd1,
    CFG_WINDOW_START  = 3'd2,
    CFG_WINDOW_END    = 3'd3,
    CFG_QUALITY_FLOOR = 3'd4,
    CFG_OBJECT_LIMIT  = 3'd5,
    CFG_INITIAL_MIN   = 3'd6
  } spa_cfg_idx_t;

  typedef enum logic [1:0] {
    ALERT_NONE   = 2'd0,
    ALERT_RED    = 2'd1,
    ALERT_YELLOW = 2'd2,
    ALERT_GREEN  = 2'd3
  } spa_alert_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } spa_state_t;

  // Status of the table walk back to the control logic.
  typedef struct packed {
    logic       busy;
    logic       done;
    logic [7:0] count;
  } spa_walk_stat_t;

endpackage

>>> hw/rtl/spa_table.sv
module spa_table
  import spa_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_idx,
  input  logic [15:0]                    wr_data,
  input  logic                           walk_start,
  input  logic [15:0]                    object_limit,
  output spa_walk_stat_t                 stat
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL     = CNT_W'(TABLE_DEPTH);

  logic [15:0] mem [TABLE_DEPTH];

  logic [15:0]      rd_data_r;
  logic [CNT_W-1:0] fill_r,    fill_nxt;
  logic             busy_r,    busy_nxt;
  logic [IDX_W-1:0] rd_idx_r,  rd_idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             rd_zero_r, rd_zero_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic             in_obj_r,  in_obj_nxt;
  logic [7:0]       count_r,   count_nxt;
  logic             done_r,    done_nxt;
  logic [15:0]      entry;

  // Writes run from index zero upward, so entries at or past the fill mark
  // were never written; the memory has no reset, so the walk reads them as zero.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  assign entry = rd_zero_r ? 16'd0 : rd_data_r;

  always_comb begin
    fill_nxt    = fill_r;
    busy_nxt    = busy_r;
    rd_idx_nxt  = rd_idx_r;
    rd_pend_nxt = 1'b0;
    rd_zero_nxt = rd_zero_r;
    rd_last_nxt = rd_last_r;
    in_obj_nxt  = in_obj_r;
    count_nxt   = count_r;
    done_nxt    = rd_pend_r && rd_last_r;

    if (wr_en && ({1'b0, wr_idx} == fill_r) && (fill_r != FULL)) begin
      fill_nxt = fill_r + CNT_W'(1);
    end

    if (walk_start) begin
      busy_nxt   = 1'b1;
      rd_idx_nxt = '0;
      in_obj_nxt = 1'b0;
      count_nxt  = '0;
    end else if (busy_r) begin
      rd_pend_nxt = 1'b1;
      rd_zero_nxt = {1'b0, rd_idx_r} >= fill_r;
      rd_last_nxt = rd_idx_r == LAST_IDX;
      if (rd_idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end else begin
        rd_idx_nxt = rd_idx_r + IDX_W'(1);
      end
    end

    if (rd_pend_r) begin
      if (!in_obj_r && entry < object_limit) begin
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + 8'd1;
        end
        in_obj_nxt = 1'b1;
      end else if (in_obj_r && entry > object_limit) begin
        in_obj_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      busy_r    <= 1'b0;
      rd_pend_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      busy_r    <= busy_nxt;
      rd_pend_r <= rd_pend_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r  <= rd_idx_nxt;
    rd_zero_r <= rd_zero_nxt;
    rd_last_r <= rd_last_nxt;
    in_obj_r  <= in_obj_nxt;
    count_r   <= count_nxt;
  end

  assign stat.busy  = busy_r || rd_pend_r;
  assign stat.done  = done_r;
  assign stat.count = count_r;

`include "scan_proximity_alert_macros.svh"

  `SPA_ASSERT_IMPLY(a_no_write_in_walk, wr_en, !busy_r && !rd_pend_r, "table write during walk")
  `SPA_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_r <= FULL, "fill mark beyond table depth")
  `SPA_ASSERT_NEXT(a_start_busy, walk_start, busy_r && !done_r, "walk did not start")

endmodule

>>> hw/rtl/scan_proximity_alert.sv
// Proximity watch over a rotating range scanner. Ordinary points are taken
// one per cycle: a point inside the angle window with enough quality lands in
// the distance table and may lower the running minimum. A turn-start point
// is not stored; it closes the turn and holds off further requests while the
// single-port table is walked one entry a cycle to count objects, and after
// that while the previous result still waits on out_stall. The result (turn
// minimum, object count, debounced alert) then sits in an output register
// while new points are accepted. No clearing pass follows reset: a fill
// mark makes unwritten table entries read as zero.
module scan_proximity_alert
  import spa_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int RED_TURNS   = RED_TURNS_DEF,
  parameter int GREEN_TURNS = GREEN_TURNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_point_distance,
  input  logic [14:0] in_point_angle,
  input  logic [5:0]  in_point_quality,
  input  logic        in_turn_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_turn_min,
  output logic [7:0]  out_object_count,
  output logic [1:0]  out_alert_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  logic [15:0] near_limit_r;
  logic [15:0] warn_limit_r;
  logic [14:0] window_start_r;
  logic [14:0] window_end_r;
  logic [5:0]  quality_floor_r;
  logic [15:0] object_limit_r;
  logic [15:0] initial_min_r;

  spa_state_t       state_r, state_nxt;
  logic [15:0]      running_min_r, running_min_nxt;
  logic [IDX_W-1:0] write_idx_r,   write_idx_nxt;
  logic [1:0]       red_hits_r,    red_hits_nxt;
  logic [4:0]       green_hits_r,  green_hits_nxt;
  spa_alert_t       alert_r,       alert_nxt;
  logic [15:0]      turn_min_r,    turn_min_nxt;
  logic             out_valid_r,   out_valid_nxt;
  logic [15:0]      out_min_r;
  logic [7:0]       out_count_r;
  logic [1:0]       out_alert_r;

  logic           accept, accept_turn, accept_point, in_window;
  logic           walk_start, emit_load;
  logic [2:0]     red_inc;
  logic [5:0]     green_inc;
  spa_walk_stat_t walk_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_limit_r    <= NEAR_LIMIT_RST;
      warn_limit_r    <= WARN_LIMIT_RST;
      window_start_r  <= WINDOW_START_RST;
      window_end_r    <= WINDOW_END_RST;
      quality_floor_r <= QUALITY_FLOOR_RST;
      object_limit_r  <= OBJECT_LIMIT_RST;
      initial_min_r   <= INITIAL_MIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEAR_LIMIT:    near_limit_r    <= cfg_data[15:0];
        CFG_WARN_LIMIT:    warn_limit_r    <= cfg_data[15:0];
        CFG_WINDOW_START:  window_start_r  <= cfg_data[14:0];
        CFG_WINDOW_END:    window_end_r    <= cfg_data[14:0];
        CFG_QUALITY_FLOOR: quality_floor_r <= cfg_data[5:0];
        CFG_OBJECT_LIMIT:  object_limit_r  <= cfg_data[15:0];
        CFG_INITIAL_MIN:   initial_min_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_turn_start) state_nxt = ST_WALK;
      ST_WALK: if (walk_stat.done) state_nxt = ST_EMIT;
      ST_EMIT: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall   = 1'b1;
    walk_start = 1'b0;
    emit_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        walk_start = in_valid && in_turn_start;
      end
      ST_WALK: ;
      ST_EMIT: emit_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  assign accept       = in_valid && !in_stall;
  assign accept_turn  = accept && in_turn_start;
  assign in_window    = (in_point_angle >= window_start_r) && (in_point_angle < window_end_r)
                        && (in_point_quality > quality_floor_r);
  assign accept_point = accept && !in_turn_start && in_window;

  assign red_inc   = {1'b0, red_hits_r} + 3'd1;
  assign green_inc = {1'b0, green_hits_r} + 6'd1;

  always_comb begin
    running_min_nxt = running_min_r;
    write_idx_nxt   = write_idx_r;
    red_hits_nxt    = red_hits_r;
    green_hits_nxt  = green_hits_r;
    alert_nxt       = alert_r;
    turn_min_nxt    = turn_min_r;

    if (accept_turn) begin
      turn_min_nxt    = running_min_r;
      running_min_nxt = initial_min_r;
      write_idx_nxt   = '0;
      if (running_min_r <= near_limit_r) begin
        green_hits_nxt = '0;
        if (red_inc >= 3'(RED_TURNS)) begin
          alert_nxt    = ALERT_RED;
          red_hits_nxt = '0;
        end else begin
          red_hits_nxt = red_inc[1:0];
        end
      end else if (running_min_r < warn_limit_r) begin
        red_hits_nxt   = '0;
        green_hits_nxt = '0;
        alert_nxt      = ALERT_YELLOW;
      end else begin
        red_hits_nxt = '0;
        if (green_inc >= 6'(GREEN_TURNS)) begin
          alert_nxt      = ALERT_GREEN;
          green_hits_nxt = '0;
        end else begin
          green_hits_nxt = green_inc[4:0];
        end
      end
    end else if (accept_point) begin
      if (in_point_distance != 16'd0 && in_point_distance < running_min_r) begin
        running_min_nxt = in_point_distance;
      end
      write_idx_nxt = (write_idx_r == LAST_IDX) ? '0 : write_idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      running_min_r <= '0;
      write_idx_r   <= '0;
      red_hits_r    <= '0;
      green_hits_r  <= '0;
      alert_r       <= ALERT_NONE;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      running_min_r <= running_min_nxt;
      write_idx_r   <= write_idx_nxt;
      red_hits_r    <= red_hits_nxt;
      green_hits_r  <= green_hits_nxt;
      alert_r       <= alert_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Hold the turn summary until the walk finishes, then load the result once the output register is free.
  always_ff @(posedge clk) begin
    turn_min_r <= turn_min_nxt;
    if (emit_load) begin
      out_min_r   <= turn_min_r;
      out_count_r <= walk_stat.count;
      out_alert_r <= alert_r;
    end
  end

  spa_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (accept_point),
    .wr_idx       (write_idx_r),
    .wr_data      (in_point_distance),
    .walk_start   (walk_start),
    .object_limit (object_limit_r),
    .stat         (walk_stat)
  );

  assign out_valid        = out_valid_r;
  assign out_turn_min     = out_min_r;
  assign out_object_count = out_count_r;
  assign out_alert_level  = out_alert_r;

`include "scan_proximity_alert_macros.svh"

  `SPA_ASSERT_NEXT(a_turn_walks, accept_turn, state_r == ST_WALK, "turn start did not begin walk")
  `SPA_ASSERT_IMPLY(a_no_overwrite, emit_load, !(out_valid_r && out_stall), "pending result lost")
  `SPA_ASSERT_IMPLY(a_done_in_walk, walk_stat.done, state_r == ST_WALK, "walk done outside walk")
  `SPA_ASSERT_IMPLY(a_idle_table, state_r == ST_IDLE, !walk_stat.busy, "table busy while idle")

endmodule

>>> sim/scan_proximity_alert_tb.sv
module scan_proximity_alert_tb;
  import spa_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [15:0] turn_min;
    logic [7:0]  objects;
    logic [1:0]  level;
  } turn_summary_t;

  typedef enum logic [1:0] {MODE_NEAR, MODE_WARN, MODE_FAR} turn_mode_t;

  // Tracks the scanner state and holds the turn summaries still to come.
  class proximity_tracker;
    logic [15:0]   near_lim, warn_lim, obj_lim, init_min;
    logic [14:0]   win_lo, win_hi;
    logic [5:0]    q_floor;
    logic [15:0]   run_min;
    logic [15:0]   ranges [TABLE_DEPTH_DEF];
    int unsigned   wr_ptr, red_run, green_run;
    spa_alert_t    alert;
    turn_summary_t summaries [$];
    int unsigned   mismatch_count;

    function new();
      near_lim  = NEAR_LIMIT_RST;
      warn_lim  = WARN_LIMIT_RST;
      win_lo    = WINDOW_START_RST;
      win_hi    = WINDOW_END_RST;
      q_floor   = QUALITY_FLOOR_RST;
      obj_lim   = OBJECT_LIMIT_RST;
      init_min  = INITIAL_MIN_RST;
      run_min   = '0;
      foreach (ranges[k]) ranges[k] = '0;
      wr_ptr    = 0;
      red_run   = 0;
      green_run = 0;
      alert     = ALERT_NONE;
      mismatch_count = 0;
    endfunction

    function void apply_reg(spa_cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_NEAR_LIMIT:    near_lim = data[15:0];
        CFG_WARN_LIMIT:    warn_lim = data[15:0];
        CFG_WINDOW_START:  win_lo   = data[14:0];
        CFG_WINDOW_END:    win_hi   = data[14:0];
        CFG_QUALITY_FLOOR: q_floor  = data[5:0];
        CFG_OBJECT_LIMIT:  obj_lim  = data[15:0];
        CFG_INITIAL_MIN:   init_min = data[15:0];
        default: ;
      endcase
    endfunction

    function void take_point(logic [15:0] d, logic [14:0] a, logic [5:0] q, logic ts);
      turn_summary_t s;
      bit            in_obj;
      int unsigned   n;
      if (ts) begin
        in_obj = 1'b0;
        n = 0;
        // walk the whole table: an entry below the limit opens an object,
        // one above it closes the object again
        for (int k = 0; k < TABLE_DEPTH_DEF; k++) begin
          if (!in_obj && ranges[k] < obj_lim) begin
            if (n < COUNT_MAX) n++;
            in_obj = 1'b1;
          end else if (in_obj && ranges[k] > obj_lim) begin
            in_obj = 1'b0;
          end
        end
        if (run_min <= near_lim) begin
          red_run++;
          green_run = 0;
          if (red_run >= RED_TURNS_DEF) begin
            alert = ALERT_RED;
            red_run = 0;
          end
        end else if (run_min < warn_lim) begin
          red_run = 0;
          green_run = 0;
          alert = ALERT_YELLOW;
        end else begin
          green_run++;
          red_run = 0;
          if (green_run >= GREEN_TURNS_DEF) begin
            alert = ALERT_GREEN;
            green_run = 0;
          end
        end
        s.turn_min = run_min;
        s.objects  = 8'(n);
        s.level    = alert;
        summaries.push_back(s);
        wr_ptr  = 0;
        run_min = init_min;
      end else if (a >= win_lo && a < win_hi && q > q_floor) begin
        if (d != 0 && d < run_min) run_min = d;
        ranges[wr_ptr] = d;
        wr_ptr = (wr_ptr + 1) % TABLE_DEPTH_DEF;
      end
    endfunction

    function void check_summary(logic [15:0] tmin, logic [7:0] objs, logic [1:0] lvl);
      turn_summary_t s;
      if (summaries.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected turn summary: min %0d objects %0d alert %0d", tmin, objs, lvl);
        return;
      end
      s = summaries.pop_front();
      if (tmin !== s.turn_min || objs !== s.objects || lvl !== s.level) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("mismatch: exp min %0d obj %0d alert %0d, got min %0d obj %0d alert %0d",
                   s.turn_min, s.objects, s.level, tmin, objs, lvl);
      end
    endfunction

    function int unsigned pending();
      return summaries.size();
    endfunction

    function int unsigned failures();
      return mismatch_count + summaries.size();
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [15:0]  in_point_distance = '0;
  logic [14:0]  in_point_angle = '0;
  logic [5:0]   in_point_quality = '0;
  logic         in_turn_start = 1'b0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [15:0]  out_turn_min;
  logic [7:0]   out_object_count;
  logic [1:0]   out_alert_level;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = CFG_NEAR_LIMIT;
  logic [31:0]  cfg_data = '0;

  proximity_tracker tracker = new();
  int unsigned      items_sent = 0;
  int unsigned      idle_cycles = 0;
  bit               steady = 1'b0;

  scan_proximity_alert uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Score every handshake and watch for a hung block.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall)
        tracker.check_summary(out_turn_min, out_object_count, out_alert_level);
      if (in_valid && !in_stall)
        tracker.take_point(in_point_distance, in_point_angle, in_point_quality, in_turn_start);
      if (cfg_valid && cfg_ready)
        tracker.apply_reg(spa_cfg_idx_t'(cfg_index), cfg_data);
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : result_backpressure
    int unsigned free_len, hold_len, pick;
    forever begin
      @(posedge clk);
      pick = $urandom_range(0, 99);
      free_len = (pick < 15) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      pick = $urandom_range(0, 99);
      if (pick < 70) hold_len = $urandom_range(1, 3);
      else if (pick < 93) hold_len = $urandom_range(4, 12);
      else hold_len = $urandom_range(20, 60);
      out_stall <= 1'b0;
      repeat (free_len) @(posedge clk);
      out_stall <= 1'b1;
      repeat (hold_len - 1) @(posedge clk);
    end
  end

  task automatic send_point(input logic [15:0] d, input logic [14:0] a,
                            input logic [5:0] q, input logic ts);
    int unsigned pick, gap;
    pick = $urandom_range(0, 99);
    if (steady || pick < 55) gap = 0;
    else if (pick < 88) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_point_distance <= d;
    in_point_angle    <= a;
    in_point_quality  <= q;
    in_turn_start     <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Hold requests until every turn summary is out, then let the pipe settle.
  task automatic drain(input int unsigned settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input spa_cfg_idx_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] near_v, warn_v, input logic [14:0] lo_v, hi_v,
                              input logic [5:0] q_v, input logic [15:0] obj_v, init_v);
    drain(SETTLE_CYCLES);
    cfg_write(CFG_NEAR_LIMIT, 32'(near_v));
    cfg_write(CFG_WARN_LIMIT, 32'(warn_v));
    cfg_write(CFG_WINDOW_START, 32'(lo_v));
    cfg_write(CFG_WINDOW_END, 32'(hi_v));
    cfg_write(CFG_QUALITY_FLOOR, 32'(q_v));
    cfg_write(CFG_OBJECT_LIMIT, 32'(obj_v));
    cfg_write(CFG_INITIAL_MIN, 32'(init_v));
    cfg_valid <= 1'b0;
  endtask

  // Runs of turns that share a character (near, warning or far), so that the
  // alert debounce gets to fire; a share of the points is plain noise.
  task automatic run_phase(input int unsigned budget, input int unsigned max_pts);
    int unsigned stop_at, run_len, npts, pick;
    int          v;
    turn_mode_t  mode;
    logic [15:0] d;
    logic [14:0] a;
    logic [5:0]  q;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      mode = turn_mode_t'($urandom_range(0, 2));
      if (mode == MODE_FAR && $urandom_range(0, 1) == 1) run_len = $urandom_range(15, 25);
      else run_len = $urandom_range(1, 5);
      repeat (run_len) begin
        if (items_sent >= stop_at) break;
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 19) == 0) drain(0);
        send_point(16'($urandom), 15'($urandom_range(0, 23039)), 6'($urandom), 1'b1);
        npts = $urandom_range(0, (mode == MODE_FAR && max_pts > 2) ? 2 : max_pts);
        repeat (npts) begin
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            d = '0;
          end else if (mode != MODE_FAR && pick < 18) begin
            v = int'(tracker.obj_lim) + int'($urandom_range(0, 4)) - 2;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
            d = 16'(v);
          end else if (pick < ((mode == MODE_FAR) ? 13 : 40)) begin
            d = 16'($urandom);
          end else begin
            case (mode)
              MODE_NEAR: d = 16'($urandom_range(0, tracker.near_lim));
              MODE_WARN: d = 16'($urandom_range(tracker.near_lim, tracker.warn_lim));
              default:   d = 16'($urandom_range(tracker.warn_lim, 16'hFFFF));
            endcase
          end
          pick = $urandom_range(0, 99);
          if (pick < 70 && tracker.win_lo < tracker.win_hi) begin
            v = $urandom_range(tracker.win_lo, tracker.win_hi - 1);
          end else if (pick < 82) begin
            case ($urandom_range(0, 2))
              0:       v = tracker.win_lo;
              1:       v = int'(tracker.win_hi) - 1;
              default: v = tracker.win_hi;
            endcase
          end else begin
            v = $urandom_range(0, 23039);
          end
          if (v < 0) v = 0;
          if (v > 23039) v = 23039;
          a = 15'(v);
          pick = $urandom_range(0, 99);
          if (pick < 80 && tracker.q_floor < 63) q = 6'($urandom_range(tracker.q_floor + 1, 63));
          else if (pick < 88) q = tracker.q_floor;
          else q = 6'($urandom);
          send_point(d, a, q, 1'b0);
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [14:0] lo_v, hi_v;
    logic [5:0]  q_v;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // No turn seen yet: the minimum sits at zero and no point can lower it.
    send_point(16'd100, 15'd0, 6'd63, 1'b0);
    send_point(16'hFFFF, 15'd23039, 6'd1, 1'b0);
    send_point(16'd0, 15'd100, 6'd5, 1'b0);
    send_point(16'd50, 15'd200, 6'd0, 1'b0);
    send_point(16'hFFFF, 15'd23039, 6'd63, 1'b1);
    // Distances right on the object, warning and near limits.
    send_point(16'd4000, 15'd11520, 6'd32, 1'b0);
    send_point(16'd3999, 15'd16384, 6'd42, 1'b0);
    send_point(16'd2000, 15'd21845, 6'd21, 1'b0);
    send_point(16'd0, 15'd0, 6'd0, 1'b1);
    send_point(16'd1, 15'd1, 6'd63, 1'b0);
    send_point(16'd1234, 15'd7000, 6'd9, 1'b1);
    send_point(16'd2001, 15'd5000, 6'd2, 1'b0);
    send_point(16'd3000, 15'd9000, 6'd3, 1'b1);
    send_point(16'd4000, 15'd12000, 6'd4, 1'b0);
    send_point(16'd777, 15'd300, 6'd7, 1'b1);
    // A zero distance means no return and leaves the minimum alone.
    send_point(16'd0, 15'd400, 6'd11, 1'b0);
    send_point(16'd0, 15'd0, 6'd0, 1'b1);
    send_point(16'd12, 15'd22000, 6'd50, 1'b1);
    send_point(16'h5555, 15'h2AAA, 6'h2A, 1'b0);
    send_point(16'hAAAA, 15'h5555, 6'h15, 1'b0);
    send_point(16'h7FFF, 15'd22000, 6'd1, 1'b1);

    lo_v = 15'($urandom_range(0, 2000));
    hi_v = 15'($urandom_range(20000, 23040));
    q_v  = 6'($urandom_range(0, 10));
    program_regs(16'($urandom_range(1000, 3000)), 16'($urandom_range(3001, 6000)), lo_v, hi_v,
                 q_v, 16'($urandom_range(2000, 6000)), 16'hFFFF);
    // One long turn: fill the table past its last entry so the index wraps.
    steady = 1'b0;
    send_point(16'($urandom), 15'($urandom_range(0, 23039)), 6'($urandom), 1'b1);
    repeat (TABLE_DEPTH_DEF + 6)
      send_point(16'($urandom), 15'($urandom_range(lo_v, hi_v - 1)),
                 6'($urandom_range(q_v + 1, 63)), 1'b0);
    run_phase(50, 12);

    // Nothing passes the quality floor: every turn is far, so green comes.
    program_regs(16'd0, 16'hFFFF, 15'd0, 15'd23040, 6'd63, 16'd0, 16'hFFFF);
    run_phase(55, 2);

    // Inverted window and a zero start minimum: every turn is near.
    program_regs(16'hFFFF, 16'd0, 15'd20000, 15'd100, 6'd0, 16'hFFFF, 16'd0);
    run_phase(30, 12);

    // A window one angle wide at the top of the range.
    program_regs(16'($urandom), 16'hFFFF, 15'd23039, 15'd23040, 6'd0, 16'hFFFF, 16'($urandom));
    run_phase(45, 10);

    program_regs(16'($urandom), 16'($urandom), 15'($urandom_range(0, 23039)),
                 15'($urandom_range(0, 23040)), 6'($urandom), 16'($urandom), 16'($urandom));
    run_phase(55, 12);

    // Empty window with equal bounds.
    program_regs(16'd1500, 16'd3500, 15'd0, 15'd0, 6'd5, 16'd3000, 16'hFFFF);
    run_phase(30, 10);

    drain(SETTLE_CYCLES);
    if (tracker.failures() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
